// ----- rtl/imusbc_pkg.sv -----
// Package for the IMU still-bias calibrator: widths, codes and the structs
// that pass between the register file, controller and datapath.
// Depends on nothing.
package imusbc_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int LIM_W      = 15;
	localparam int CPG_W      = 15;
	localparam int CNT_W      = 16;
	localparam int OUT_W      = 16;
	localparam int SUM_W      = 40;
	localparam int MAG_W      = 32;
	localparam int FRAC_BITS  = 11;
	localparam int SQ_W       = 2 * SAMPLE_W;
	localparam int RAD_W      = SQ_W;
	localparam int ROOT_STEPS = RAD_W / 2;
	localparam int DVD_W      = MAG_W + FRAC_BITS;
	localparam int DVS_W      = CNT_W + CPG_W;
	localparam int DIV_STEPS  = DVD_W;
	localparam int ITER_W     = $clog2(DIV_STEPS);
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;
	localparam int STATUS_W   = 2;

	localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MOTION = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DONE   = 2'd2;

	localparam logic [1:0] REG_LIMIT  = 2'd0;
	localparam logic [1:0] REG_CPG    = 2'd1;
	localparam logic [1:0] REG_TARGET = 2'd2;

	localparam logic [LIM_W-1:0] LIMIT_RST  = 15'd66;
	localparam logic [CPG_W-1:0] CPG_RST    = 15'd4096;
	localparam logic [CNT_W-1:0] TARGET_RST = 16'd1000;

	localparam logic [1:0] DIV_X     = 2'd0;
	localparam logic [1:0] DIV_Y     = 2'd1;
	localparam logic [1:0] DIV_Z     = 2'd2;
	localparam logic [1:0] DIV_SCALE = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] acc_x;
		logic signed [SAMPLE_W-1:0] acc_y;
		logic signed [SAMPLE_W-1:0] acc_z;
		logic signed [SAMPLE_W-1:0] rate_x;
		logic signed [SAMPLE_W-1:0] rate_y;
		logic signed [SAMPLE_W-1:0] rate_z;
	} smp_t;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic [CNT_W-1:0]        still_count;
		logic signed [OUT_W-1:0] bias_x;
		logic signed [OUT_W-1:0] bias_y;
		logic signed [OUT_W-1:0] bias_z;
		logic [OUT_W-1:0]        accel_scale;
	} res_t;

	typedef struct packed {
		logic [LIM_W-1:0] limit;
		logic [CPG_W-1:0] cpg;
		logic [CNT_W-1:0] target;
	} cfg_t;

	typedef struct packed {
		logic                load_in;
		logic                sq_load;
		logic                rad_load;
		logic                root_step;
		logic                accum;
		logic                clear_run;
		logic                den_load;
		logic                div_load;
		logic                div_step;
		logic                div_capture;
		logic                out_load;
		logic [1:0]          div_sel;
		logic [STATUS_W-1:0] status;
	} cmd_t;

	typedef struct packed {
		logic still;
		logic complete;
	} sts_t;

endpackage

// ----- rtl/imusbc_ifs.sv -----
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on imusbc_pkg.
interface imusbc_sample_if import imusbc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] acc_x;
	logic signed [SAMPLE_W-1:0] acc_y;
	logic signed [SAMPLE_W-1:0] acc_z;
	logic signed [SAMPLE_W-1:0] rate_x;
	logic signed [SAMPLE_W-1:0] rate_y;
	logic signed [SAMPLE_W-1:0] rate_z;

	modport source (output valid, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, input ready);
	modport sink (input valid, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, output ready);
endinterface

interface imusbc_result_if import imusbc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic [CNT_W-1:0]        still_count;
	logic signed [OUT_W-1:0] bias_x;
	logic signed [OUT_W-1:0] bias_y;
	logic signed [OUT_W-1:0] bias_z;
	logic [OUT_W-1:0]        accel_scale;

	modport source (output valid, status, still_count, bias_x, bias_y, bias_z, accel_scale,
		input ready);
	modport sink (input valid, status, still_count, bias_x, bias_y, bias_z, accel_scale,
		output ready);
endinterface

// ----- rtl/imusbc_regs.sv -----
// APB-style configuration registers: still limit, counts per g, sample target.
// Depends on imusbc_pkg.
module imusbc_regs import imusbc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [1:0] idx;

	assign idx = paddr[ADDR_W-1:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit  <= LIMIT_RST;
			cfg_q.cpg    <= CPG_RST;
			cfg_q.target <= TARGET_RST;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_LIMIT:  cfg_q.limit  <= pwdata[LIM_W-1:0];
				REG_CPG:    cfg_q.cpg    <= pwdata[CPG_W-1:0];
				REG_TARGET: cfg_q.target <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LIMIT:  prdata = DATA_W'(cfg_q.limit);
			REG_CPG:    prdata = DATA_W'(cfg_q.cpg);
			REG_TARGET: prdata = DATA_W'(cfg_q.target);
			default:    prdata = '0;
		endcase
	end

endmodule

// ----- rtl/imusbc_div.sv -----
// Restoring divider, one quotient bit per step, shared by the bias and scale
// divisions. Depends on imusbc_pkg.
module imusbc_div import imusbc_pkg::*; (
	input  logic             clk,
	input  logic             load,
	input  logic             step,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient
);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] dq_q;
	logic [DVS_W:0]   shifted;
	logic             fits;

	assign shifted  = {rem_q, dq_q[DVD_W-1]};
	assign fits     = shifted >= {1'b0, dvs_q};
	assign quotient = dq_q;

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			dvs_q <= divisor;
			dq_q  <= dividend;
		end else if (step) begin
			rem_q <= fits ? DVS_W'(shifted - {1'b0, dvs_q}) : shifted[DVS_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], fits};
		end
	end

endmodule

// ----- rtl/imusbc_dp.sv -----
// Datapath: stillness check, squares, iterative square root, running sums,
// the shared divider and the result register. Depends on imusbc_pkg, imusbc_div.
module imusbc_dp import imusbc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  cfg_t cfg,
	input  smp_t smp,
	output sts_t sts,
	output res_t res
);

	smp_t                    in_q;
	logic [SQ_W-1:0]         sq_x_q, sq_y_q, sq_z_q;
	logic [RAD_W-1:0]        rad_q, root_q, bit_q;
	logic signed [SUM_W-1:0] rate_sum_x_q, rate_sum_y_q, rate_sum_z_q;
	logic [MAG_W-1:0]        mag_sum_q;
	logic [CNT_W-1:0]        still_q;
	logic [DVS_W-1:0]        den_q;
	logic signed [OUT_W-1:0] bias_x_q, bias_y_q, bias_z_q;
	logic [OUT_W-1:0]        scale_q;
	res_t                    res_q;

	logic signed [SQ_W-1:0]  px, py, pz;
	logic [RAD_W:0]          trial;
	logic [CNT_W-1:0]        cnt_next, target_eff;
	logic [CPG_W-1:0]        cpg_eff;
	logic [DVD_W-1:0]        dividend, quot;
	logic [DVS_W-1:0]        divisor;
	logic signed [SUM_W-1:0] sel_sum;
	logic [SUM_W-1:0]        sel_abs;
	logic [OUT_W-1:0]        q_signed;

	function automatic logic [SAMPLE_W:0] gyro_mag(input logic signed [SAMPLE_W-1:0] v);
		logic signed [SAMPLE_W:0] w;
		w = (SAMPLE_W + 1)'(v);
		return w[SAMPLE_W] ? unsigned'(-w) : unsigned'(w);
	endfunction

	assign sts.still = (32'(gyro_mag(in_q.rate_x)) < 32'(cfg.limit))
		&& (32'(gyro_mag(in_q.rate_y)) < 32'(cfg.limit))
		&& (32'(gyro_mag(in_q.rate_z)) < 32'(cfg.limit));

	assign cnt_next     = still_q + CNT_W'(1);
	assign target_eff   = (cfg.target == '0) ? CNT_W'(1) : cfg.target;
	assign sts.complete = (cnt_next != '0) && (cnt_next >= target_eff);
	assign cpg_eff      = (cfg.cpg == '0) ? CPG_W'(1) : cfg.cpg;

	assign px    = in_q.acc_x * in_q.acc_x;
	assign py    = in_q.acc_y * in_q.acc_y;
	assign pz    = in_q.acc_z * in_q.acc_z;
	assign trial = {1'b0, root_q} + {1'b0, bit_q};

	always_comb begin
		case (cmd.div_sel)
			DIV_X:   sel_sum = rate_sum_x_q;
			DIV_Y:   sel_sum = rate_sum_y_q;
			default: sel_sum = rate_sum_z_q;
		endcase
		sel_abs  = sel_sum[SUM_W-1] ? unsigned'(-sel_sum) : unsigned'(sel_sum);
		q_signed = sel_sum[SUM_W-1] ? OUT_W'(-quot[OUT_W-1:0]) : quot[OUT_W-1:0];
		if (cmd.div_sel == DIV_SCALE) begin
			dividend = {mag_sum_q, FRAC_BITS'(0)};
			divisor  = den_q;
		end else begin
			dividend = DVD_W'(sel_abs);
			divisor  = DVS_W'(still_q);
		end
	end

	imusbc_div u_div (
		.clk      (clk),
		.load     (cmd.div_load),
		.step     (cmd.div_step),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_sum_x_q <= '0;
			rate_sum_y_q <= '0;
			rate_sum_z_q <= '0;
			mag_sum_q    <= '0;
			still_q      <= '0;
		end else if (cmd.clear_run) begin
			rate_sum_x_q <= '0;
			rate_sum_y_q <= '0;
			rate_sum_z_q <= '0;
			mag_sum_q    <= '0;
			still_q      <= '0;
		end else if (cmd.accum) begin
			rate_sum_x_q <= rate_sum_x_q + SUM_W'(in_q.rate_x);
			rate_sum_y_q <= rate_sum_y_q + SUM_W'(in_q.rate_y);
			rate_sum_z_q <= rate_sum_z_q + SUM_W'(in_q.rate_z);
			mag_sum_q    <= mag_sum_q + MAG_W'(root_q);
			still_q      <= cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= smp;
		end
		if (cmd.sq_load) begin
			sq_x_q <= unsigned'(px);
			sq_y_q <= unsigned'(py);
			sq_z_q <= unsigned'(pz);
		end
		if (cmd.rad_load) begin
			rad_q  <= sq_x_q + sq_y_q + sq_z_q;
			root_q <= '0;
			bit_q  <= RAD_W'(1) << (RAD_W - 2);
		end else if (cmd.root_step) begin
			if ({1'b0, rad_q} >= trial) begin
				rad_q  <= RAD_W'({1'b0, rad_q} - trial);
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.den_load) begin
			den_q <= still_q * cpg_eff;
		end
		if (cmd.div_capture) begin
			case (cmd.div_sel)
				DIV_X: bias_x_q <= q_signed;
				DIV_Y: bias_y_q <= q_signed;
				DIV_Z: bias_z_q <= q_signed;
				default: begin
					scale_q <= (|quot[DVD_W-1:OUT_W]) ? '1 : quot[OUT_W-1:0];
				end
			endcase
		end
		if (cmd.out_load) begin
			res_q.status      <= cmd.status;
			res_q.still_count <= still_q;
			if (cmd.status == ST_DONE) begin
				res_q.bias_x      <= bias_x_q;
				res_q.bias_y      <= bias_y_q;
				res_q.bias_z      <= bias_z_q;
				res_q.accel_scale <= scale_q;
			end else begin
				res_q.bias_x      <= '0;
				res_q.bias_y      <= '0;
				res_q.bias_z      <= '0;
				res_q.accel_scale <= '0;
			end
		end
	end

	assign res = res_q;

endmodule

// ----- rtl/imusbc_ctrl.sv -----
// Controller state machine: sequences the datapath and owns both handshakes.
// Depends on imusbc_pkg.
module imusbc_ctrl import imusbc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_ADD, S_ROOT, S_ACC, S_MUL, S_DIVLD, S_DIV, S_CAP, S_OUT
	} state_t;

	state_t              state_q;
	logic [ITER_W-1:0]   cnt_q;
	logic [1:0]          sel_q;
	logic [STATUS_W-1:0] kind_q;
	logic                out_valid_q;
	logic                out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd         = '0;
		cmd.div_sel = sel_q;
		cmd.status  = kind_q;
		unique case (state_q)
			S_IDLE:  cmd.load_in = in_valid;
			S_CHK: begin
				cmd.sq_load   = 1'b1;
				cmd.clear_run = !sts.still;
			end
			S_ADD:   cmd.rad_load = 1'b1;
			S_ROOT:  cmd.root_step = 1'b1;
			S_ACC:   cmd.accum = 1'b1;
			S_MUL:   cmd.den_load = 1'b1;
			S_DIVLD: cmd.div_load = 1'b1;
			S_DIV:   cmd.div_step = 1'b1;
			S_CAP:   cmd.div_capture = 1'b1;
			S_OUT: begin
				cmd.out_load  = out_free;
				cmd.clear_run = out_free && (kind_q == ST_DONE);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sel_q       <= DIV_X;
			kind_q      <= ST_ACCEPT;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (sts.still) begin
						state_q <= S_ADD;
					end else begin
						kind_q  <= ST_MOTION;
						state_q <= S_OUT;
					end
				end
				S_ADD: begin
					cnt_q   <= '0;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					cnt_q <= cnt_q + ITER_W'(1);
					if (cnt_q == ITER_W'(ROOT_STEPS - 1)) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (sts.complete) begin
						kind_q  <= ST_DONE;
						state_q <= S_MUL;
					end else begin
						kind_q  <= ST_ACCEPT;
						state_q <= S_OUT;
					end
				end
				S_MUL: begin
					sel_q   <= DIV_X;
					state_q <= S_DIVLD;
				end
				S_DIVLD: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + ITER_W'(1);
					if (cnt_q == ITER_W'(DIV_STEPS - 1)) begin
						state_q <= S_CAP;
					end
				end
				S_CAP: begin
					if (sel_q == DIV_SCALE) begin
						state_q <= S_OUT;
					end else begin
						sel_q   <= sel_q + 2'd1;
						state_q <= S_DIVLD;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/imu_still_bias_calibrator.sv -----
// IMU still-bias calibrator: an ordinary sample goes from acceptance to a
// loaded result through the stillness check, squares, 16 steps of the
// bit-pair square root, accumulation and output load. The sample that
// completes a run adds the count times counts-per-g product and four passes
// through the single 43-step restoring divider (x, y and z bias, then the
// scale). The result sits in an output register, so a new item is taken as
// soon as the block is back in idle, even while the previous result waits.
// Depends on imusbc_pkg, imusbc_ifs, imusbc_regs, imusbc_ctrl, imusbc_dp.
module imu_still_bias_calibrator import imusbc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	imusbc_sample_if.sink           sample,
	imusbc_result_if.source         result,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;
	smp_t smp;
	res_t res;

	assign pready = 1'b1;

	assign smp.acc_x  = sample.acc_x;
	assign smp.acc_y  = sample.acc_y;
	assign smp.acc_z  = sample.acc_z;
	assign smp.rate_x = sample.rate_x;
	assign smp.rate_y = sample.rate_y;
	assign smp.rate_z = sample.rate_z;

	assign result.status      = res.status;
	assign result.still_count = res.still_count;
	assign result.bias_x      = res.bias_x;
	assign result.bias_y      = res.bias_y;
	assign result.bias_z      = res.bias_z;
	assign result.accel_scale = res.accel_scale;

	imusbc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	imusbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	imusbc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg),
		.smp    (smp),
		.sts    (sts),
		.res    (res)
	);

endmodule
